>>> src/mfhv_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfhv_pkg: shared types and constants of the model file header validator
// Payload structs of the three channels, the classified byte entry that
// passes from the front to the back, status codes and header geometry.
// ---------------------------------------------------------------------------
package mfhv_pkg;

   localparam int BYTE_W = 8;
   localparam int BLOB_W = 48;
   localparam int WORD_W = 32;
   localparam int WIDE_W = 64;
   localparam int POS_W  = 6;

   localparam logic [POS_W-1:0] COMMON_LEN  = 6'd12;
   localparam logic [POS_W-1:0] MAX_HEADER  = 6'd52;
   localparam logic [POS_W-1:0] POS_MAX     = 6'd63;
   localparam logic [POS_W-1:0] MAGIC_END   = 6'd4;
   localparam logic [POS_W-1:0] VERSION_END = 6'd8;
   localparam logic [POS_W-1:0] CRC_END     = 6'd16;
   localparam logic [POS_W-1:0] SECT_END    = 6'd24;
   localparam logic [POS_W-1:0] HASH1_END   = 6'd32;

   localparam logic [1:0] CSR_MAGIC   = 2'd0;
   localparam logic [1:0] CSR_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_HIGHEST = 2'd2;

   localparam logic [1:0] VER_SECTION = 2'd1;
   localparam logic [1:0] VER_PLAIN   = 2'd0;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_SHORT   = 3'd1,
      ST_MAGIC   = 3'd2,
      ST_VERSION = 3'd3,
      ST_SIZE    = 3'd4,
      ST_TRUNC   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      SLOT_NONE,
      SLOT_MAGIC,
      SLOT_VERSION,
      SLOT_PSIZE,
      SLOT_CRC,
      SLOT_SECT,
      SLOT_HASH1
   } slot_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic [BLOB_W-1:0] blob_size;
      logic              start_req;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [1:0]        version;
      logic [WORD_W-1:0] payload_size;
      logic [POS_W-1:0]  payload_offset;
      logic [WORD_W-1:0] crc_word;
      logic [WIDE_W-1:0] section_size;
      logic [BLOB_W-1:0] section_offset;
      logic [WIDE_W-1:0] hash_high;
      logic [WIDE_W-1:0] hash_low;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] magic_value;
      logic [WORD_W-1:0] payload_size_limit;
      logic [1:0]        highest_version;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic [BLOB_W-1:0] sampled;
      logic [POS_W-1:0]  pos;
      logic              start_req;
      logic              short_start;
      logic              common_end;
      slot_type          slot;
   } entry_type;

   // Whole header length: common part plus the version's trailer.
   function automatic logic [POS_W-1:0] header_len(input logic [1:0] ver);
      logic [POS_W-1:0] len;
      case (ver)
         2'd0:    len = 6'd32;
         2'd1:    len = 6'd28;
         2'd2:    len = 6'd44;
         default: len = 6'd52;
      endcase
      return len;
   endfunction

   function automatic logic [POS_W-1:0] last_pos(input logic [1:0] ver);
      logic [POS_W-1:0] pos;
      case (ver)
         2'd0:    pos = 6'd31;
         2'd1:    pos = 6'd27;
         2'd2:    pos = 6'd43;
         default: pos = 6'd51;
      endcase
      return pos;
   endfunction

endpackage

>>> src/mfhv_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfhv_fifo: small register queue
// First-in first-out store with occupancy count; the caller writes only
// when not full and reads only when not empty.
// ---------------------------------------------------------------------------
module mfhv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !full)
      else $error("write into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !empty)
      else $error("read from an empty queue");

   a_write_lands: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !rd_en) |=> !empty)
      else $error("queue empty after a write without a read");

endmodule

>>> src/mfhv_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfhv_front: byte intake and classification
// Tracks the byte offset within the current blob, samples the blob size on
// the start byte and tags each byte with the header field it belongs to.
// ---------------------------------------------------------------------------
module mfhv_front #(
   parameter int SIZE_BITS = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  mfhv_pkg::req_type   req_data,
   output logic                req_full,
   input  logic                queue_full,
   output logic                entry_wr,
   output mfhv_pkg::entry_type entry
);

   localparam int BlobW = mfhv_pkg::BLOB_W;
   localparam int PosW  = mfhv_pkg::POS_W;
   localparam int SampW = (SIZE_BITS < BlobW) ? SIZE_BITS : BlobW;

   logic [PosW-1:0]  pos_ff, pos_in;
   logic [PosW-1:0]  pos;
   logic [BlobW-1:0] sampled;
   logic             accept;
   logic             keep;

   always_comb begin
      accept   = req_push && !queue_full;
      req_full = queue_full;

      sampled = '0;
      sampled[SampW-1:0] = req_data.blob_size[SampW-1:0];

      pos = req_data.start_req ? '0 : pos_ff;

      entry.data_byte   = req_data.data_byte;
      entry.sampled     = sampled;
      entry.pos         = pos;
      entry.start_req   = req_data.start_req;
      entry.short_start = req_data.start_req && (sampled < BlobW'(mfhv_pkg::COMMON_LEN));
      entry.common_end  = (pos == mfhv_pkg::COMMON_LEN - 1'b1);

      if (pos < mfhv_pkg::MAGIC_END) begin
         entry.slot = mfhv_pkg::SLOT_MAGIC;
      end else if (pos < mfhv_pkg::VERSION_END) begin
         entry.slot = mfhv_pkg::SLOT_VERSION;
      end else if (pos < mfhv_pkg::COMMON_LEN) begin
         entry.slot = mfhv_pkg::SLOT_PSIZE;
      end else if (pos < mfhv_pkg::CRC_END) begin
         entry.slot = mfhv_pkg::SLOT_CRC;
      end else if (pos < mfhv_pkg::SECT_END) begin
         entry.slot = mfhv_pkg::SLOT_SECT;
      end else if (pos < mfhv_pkg::HASH1_END) begin
         entry.slot = mfhv_pkg::SLOT_HASH1;
      end else begin
         entry.slot = mfhv_pkg::SLOT_NONE;
      end

      // Bytes beyond the longest header can never matter to the back end.
      keep     = req_data.start_req || (pos < mfhv_pkg::MAX_HEADER);
      entry_wr = accept && keep;

      pos_in = pos_ff;
      if (accept) begin
         pos_in = (pos == mfhv_pkg::POS_MAX) ? pos : pos + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

>>> src/mfhv_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfhv_back: field assembly and header checks
// Shifts classified bytes into the header fields, runs the common header
// checks on its last byte and builds the result on the last trailer byte.
// ---------------------------------------------------------------------------
module mfhv_back #(
   parameter int SIZE_BITS = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  mfhv_pkg::cfg_type   cfg,
   input  logic                entry_empty,
   input  mfhv_pkg::entry_type entry,
   output logic                entry_rd,
   input  logic                rsp_full,
   output logic                res_wr,
   output mfhv_pkg::rsp_type   res
);

   localparam int BlobW = mfhv_pkg::BLOB_W;
   localparam int WordW = mfhv_pkg::WORD_W;
   localparam int WideW = mfhv_pkg::WIDE_W;
   localparam int PosW  = mfhv_pkg::POS_W;
   localparam int SampW = (SIZE_BITS < BlobW) ? SIZE_BITS : BlobW;

   logic             active_ff,  active_in;
   logic [SampW-1:0] sampled_ff, sampled_in;
   logic [WordW-1:0] magic_ff,   magic_in;
   logic [WordW-1:0] version_ff, version_in;
   logic [WordW-1:0] psize_ff,   psize_in;
   logic [WordW-1:0] crc_ff,     crc_in;
   logic [WideW-1:0] sect_ff,    sect_in;
   logic [WideW-1:0] hash0_ff,   hash0_in;
   logic [WideW-1:0] hash1_ff,   hash1_in;
   logic [BlobW-1:0] pend_ff,    pend_in;
   logic [BlobW-1:0] remain_ff,  remain_in;

   logic [PosW-1:0]  hlen;
   logic [BlobW:0]   pend_wide;
   logic [BlobW:0]   diff_wide;
   logic             ver_bad;
   logic             hdr_short;
   logic             size_bad;
   logic             is_last;

   always_comb begin
      entry_rd   = !entry_empty && !rsp_full;
      res_wr     = 1'b0;
      res        = '0;
      active_in  = active_ff;
      sampled_in = sampled_ff;
      magic_in   = magic_ff;
      version_in = version_ff;
      psize_in   = psize_ff;
      crc_in     = crc_ff;
      sect_in    = sect_ff;
      hash0_in   = hash0_ff;
      hash1_in   = hash1_ff;
      pend_in    = pend_ff;
      remain_in  = remain_ff;

      if (entry_rd && entry.start_req) begin
         active_in  = 1'b1;
         sampled_in = entry.sampled[SampW-1:0];
         magic_in   = '0;
         version_in = '0;
         psize_in   = '0;
         crc_in     = '0;
         sect_in    = '0;
         hash0_in   = '0;
         hash1_in   = '0;
      end

      case (entry.slot)
         mfhv_pkg::SLOT_MAGIC:   magic_in   = {magic_in[WordW-9:0], entry.data_byte};
         mfhv_pkg::SLOT_VERSION: version_in = {version_in[WordW-9:0], entry.data_byte};
         mfhv_pkg::SLOT_PSIZE:   psize_in   = {psize_in[WordW-9:0], entry.data_byte};
         mfhv_pkg::SLOT_CRC:     crc_in     = {crc_in[WordW-9:0], entry.data_byte};
         mfhv_pkg::SLOT_SECT: begin
            sect_in  = {sect_in[WideW-9:0], entry.data_byte};
            hash0_in = {hash0_in[WideW-9:0], entry.data_byte};
         end
         mfhv_pkg::SLOT_HASH1:   hash1_in   = {hash1_in[WideW-9:0], entry.data_byte};
         default: ;
      endcase

      // Checks on the completed common header.
      hlen      = mfhv_pkg::header_len(version_in[1:0]);
      ver_bad   = (|version_in[WordW-1:2]) || (version_in[1:0] > cfg.highest_version);
      hdr_short = BlobW'(sampled_in) < BlobW'(hlen);
      size_bad  = (psize_in == '0) || (psize_in > cfg.payload_size_limit);
      pend_wide = (BlobW + 1)'(hlen) + (BlobW + 1)'(psize_in);
      diff_wide = (BlobW + 1)'(sampled_in) - pend_wide;
      is_last   = !entry.common_end &&
                  (entry.pos == mfhv_pkg::last_pos(version_ff[1:0]));

      if (!entry_rd) begin
         // Nothing transferred: hold all state.
         active_in  = active_ff;
         sampled_in = sampled_ff;
         magic_in   = magic_ff;
         version_in = version_ff;
         psize_in   = psize_ff;
         crc_in     = crc_ff;
         sect_in    = sect_ff;
         hash0_in   = hash0_ff;
         hash1_in   = hash1_ff;
      end else if (entry.start_req && entry.short_start) begin
         res_wr     = 1'b1;
         res.status = mfhv_pkg::ST_SHORT;
         active_in  = 1'b0;
      end else if (!(entry.start_req || active_ff)) begin
         // Idle bytes leave the fields untouched.
         magic_in   = magic_ff;
         version_in = version_ff;
         psize_in   = psize_ff;
         crc_in     = crc_ff;
         sect_in    = sect_ff;
         hash0_in   = hash0_ff;
         hash1_in   = hash1_ff;
      end else if (entry.common_end) begin
         if (magic_in != cfg.magic_value) begin
            res_wr     = 1'b1;
            res.status = mfhv_pkg::ST_MAGIC;
         end else if (ver_bad) begin
            res_wr     = 1'b1;
            res.status = mfhv_pkg::ST_VERSION;
         end else if (hdr_short) begin
            res_wr     = 1'b1;
            res.status = mfhv_pkg::ST_SHORT;
         end else if (size_bad) begin
            res_wr     = 1'b1;
            res.status = mfhv_pkg::ST_SIZE;
         end else if (diff_wide[BlobW]) begin
            // A borrow means the payload runs past the end of the blob.
            res_wr     = 1'b1;
            res.status = mfhv_pkg::ST_TRUNC;
         end else begin
            pend_in   = pend_wide[BlobW-1:0];
            remain_in = diff_wide[BlobW-1:0];
         end
         if (res_wr) begin
            active_in = 1'b0;
         end
      end else if (is_last) begin
         res_wr    = 1'b1;
         active_in = 1'b0;
         if (version_ff[1:0] == mfhv_pkg::VER_SECTION &&
             sect_in > WideW'(remain_ff)) begin
            res.status = mfhv_pkg::ST_TRUNC;
         end else begin
            res.status         = mfhv_pkg::ST_OK;
            res.version        = version_ff[1:0];
            res.payload_size   = psize_ff;
            res.payload_offset = mfhv_pkg::header_len(version_ff[1:0]);
            if (version_ff[1:0] == mfhv_pkg::VER_SECTION) begin
               res.crc_word       = crc_in;
               res.section_size   = sect_in;
               res.section_offset = pend_ff;
            end else begin
               res.hash_high = hash0_in;
               res.hash_low  = hash1_in;
               if (version_ff[1:0] != mfhv_pkg::VER_PLAIN) begin
                  res.crc_word       = crc_in;
                  res.section_size   = WideW'(remain_ff);
                  res.section_offset = pend_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      sampled_ff <= sampled_in;
      magic_ff   <= magic_in;
      version_ff <= version_in;
      psize_ff   <= psize_in;
      crc_ff     <= crc_in;
      sect_ff    <= sect_in;
      hash0_ff   <= hash0_in;
      hash1_ff   <= hash1_in;
      pend_ff    <= pend_in;
      remain_ff  <= remain_in;
   end

   a_result_ends_blob: assert property (@(posedge clock) disable iff (reset)
      res_wr |=> !active_ff)
      else $error("blob still active after its result");

   a_ok_version_allowed: assert property (@(posedge clock) disable iff (reset)
      (res_wr && res.status == mfhv_pkg::ST_OK) |-> res.version <= cfg.highest_version)
      else $error("good result with a rejected version");

   a_ok_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      (res_wr && res.status == mfhv_pkg::ST_OK) |-> res.payload_size != '0)
      else $error("good result with an empty payload");

   a_error_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (res_wr && res.status != mfhv_pkg::ST_OK) |->
         (res.payload_offset == '0 && res.section_size == '0 && res.hash_high == '0))
      else $error("error result carries header fields");

endmodule

>>> src/model_file_header_validator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// model_file_header_validator: blob header parser and checker
// Parses the big-endian common header and version trailer of a blob and
// reports one status record per blob, unless a restart cuts its header short.
// ---------------------------------------------------------------------------
// Usage:
//   Header bytes enter through a queue-style port: an item transfers on a
//   clock edge with req_push high and req_full low. The byte with start_req
//   set is offset zero; blob_size is sampled with it.
//   Results leave through a second queue-style port: while rsp_empty is low
//   the oldest result is on rsp_data and transfers when rsp_pop is high.
//   Registers are written through csr_* (always ready); the user writes them only while idle, unenforced.
// Timing:
//   One byte per cycle is accepted, sustained while req_full stays low. The
//   byte that completes a result is written into the byte queue; the field
//   assembly back end reads it from there and writes the result into the
//   result queue, from which it is popped. The back end updates its fields
//   as it reads each byte, which sets the rate.
// Reset and stalls:
//   Reset empties both queues, ends any blob in progress and restores the
//   register defaults. If results are not popped the result queue fills,
//   the back end stops draining the byte queue and req_full rises once
//   that queue is full too; nothing is lost.
// ---------------------------------------------------------------------------
module model_file_header_validator #(
   parameter int SIZE_BITS    = 48,
   parameter int QUEUE_DEPTH  = 4,
   parameter int RESULT_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  mfhv_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mfhv_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int EntryW = $bits(mfhv_pkg::entry_type);
   localparam int RspW   = $bits(mfhv_pkg::rsp_type);

   mfhv_pkg::cfg_type   cfg_ff, cfg_in;
   mfhv_pkg::entry_type entry_wdata;
   mfhv_pkg::entry_type entry_rdata;
   mfhv_pkg::rsp_type   res;
   logic                entry_wr;
   logic                entry_rd;
   logic                entry_full;
   logic                entry_empty;
   logic                res_wr;
   logic                rsp_full;
   logic                rsp_rd;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mfhv_pkg::CSR_MAGIC:   cfg_in.magic_value        = csr_wdata;
            mfhv_pkg::CSR_LIMIT:   cfg_in.payload_size_limit = csr_wdata;
            mfhv_pkg::CSR_HIGHEST: cfg_in.highest_version    = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_value        <= '0;
         cfg_ff.payload_size_limit <= '1;
         cfg_ff.highest_version    <= 2'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mfhv_front #(
      .SIZE_BITS (SIZE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .queue_full (entry_full),
      .entry_wr   (entry_wr),
      .entry      (entry_wdata)
   );

   mfhv_fifo #(
      .WIDTH (EntryW),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (entry_wr),
      .wr_data (entry_wdata),
      .rd_en   (entry_rd),
      .rd_data (entry_rdata),
      .full    (entry_full),
      .empty   (entry_empty)
   );

   mfhv_back #(
      .SIZE_BITS (SIZE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .entry_empty (entry_empty),
      .entry       (entry_rdata),
      .entry_rd    (entry_rd),
      .rsp_full    (rsp_full),
      .res_wr      (res_wr),
      .res         (res)
   );

   assign rsp_rd = rsp_pop && !rsp_empty;

   mfhv_fifo #(
      .WIDTH (RspW),
      .DEPTH (RESULT_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_wr),
      .wr_data (res),
      .rd_en   (rsp_rd),
      .rd_data (rsp_data),
      .full    (rsp_full),
      .empty   (rsp_empty)
   );

endmodule

>>> tb/sv/model_file_header_validator_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// model_file_header_validator_checker: header validator scoreboard
// Watches the byte, result and register channels of the validator, keeps
// its own copy of the registers and of the header parser, predicts the
// status record of every blob that yields one and compares each popped
// record with the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module model_file_header_validator_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  mfhv_pkg::req_type req_data,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  mfhv_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output int                mismatch_count,
   output int                awaited_count,
   output int                parsed_count
);

   localparam int TRAILER_BYTES [4] = '{20, 16, 32, 40};

   // Register copies.
   logic [31:0] cfg_magic;
   logic [31:0] cfg_limit;
   logic [1:0]  cfg_highest;

   // Parser state.
   logic        busy;
   logic [5:0]  offset;
   logic [47:0] blob_len;
   logic [31:0] magic_acc;
   logic [31:0] ver_acc;
   logic [31:0] psize_acc;
   logic [31:0] crc_acc;
   logic [63:0] sect_acc;
   logic [63:0] hash_hi_acc;
   logic [63:0] hash_lo_acc;

   mfhv_pkg::rsp_type outcomes[$];
   int          mismatches = 0;
   int          live_items = 0;

   task automatic parse_byte(input mfhv_pkg::req_type item);
      mfhv_pkg::rsp_type    res;
      logic [5:0]           pos;
      logic [63:0]          hdr_len;
      logic [63:0]          pend;
      mfhv_pkg::status_type verdict;
      logic                 failed;
      res = '0;
      live_items++;
      if (item.start_req) begin
         busy        = 1'b1;
         offset      = '0;
         blob_len    = item.blob_size;
         magic_acc   = '0;
         ver_acc     = '0;
         psize_acc   = '0;
         crc_acc     = '0;
         sect_acc    = '0;
         hash_hi_acc = '0;
         hash_lo_acc = '0;
         // A blob too short for the common header is rejected on its first byte.
         if (blob_len < 48'(mfhv_pkg::COMMON_LEN)) begin
            res.status = mfhv_pkg::ST_SHORT;
            busy = 1'b0;
            outcomes.push_back(res);
            return;
         end
      end
      if (!busy) return;

      pos = offset;
      if (pos < mfhv_pkg::MAGIC_END)
         magic_acc = {magic_acc[23:0], item.data_byte};
      else if (pos < mfhv_pkg::VERSION_END)
         ver_acc = {ver_acc[23:0], item.data_byte};
      else if (pos < mfhv_pkg::COMMON_LEN)
         psize_acc = {psize_acc[23:0], item.data_byte};
      else if (pos < mfhv_pkg::CRC_END)
         crc_acc = {crc_acc[23:0], item.data_byte};
      else if (pos < mfhv_pkg::SECT_END) begin
         sect_acc    = {sect_acc[55:0], item.data_byte};
         hash_hi_acc = {hash_hi_acc[55:0], item.data_byte};
      end else if (pos < mfhv_pkg::HASH1_END)
         hash_lo_acc = {hash_lo_acc[55:0], item.data_byte};

      hdr_len = 64'(mfhv_pkg::COMMON_LEN) + 64'(unsigned'(TRAILER_BYTES[ver_acc[1:0]]));
      pend    = hdr_len + 64'(psize_acc);

      if (pos == mfhv_pkg::COMMON_LEN - 6'd1) begin
         failed  = 1'b1;
         verdict = mfhv_pkg::ST_OK;
         if (magic_acc != cfg_magic)
            verdict = mfhv_pkg::ST_MAGIC;
         else if (ver_acc > 32'(cfg_highest))
            verdict = mfhv_pkg::ST_VERSION;
         else if (64'(blob_len) < hdr_len)
            verdict = mfhv_pkg::ST_SHORT;
         else if (psize_acc == '0 || psize_acc > cfg_limit)
            verdict = mfhv_pkg::ST_SIZE;
         else if (pend > 64'(blob_len))
            verdict = mfhv_pkg::ST_TRUNC;
         else
            failed = 1'b0;
         if (failed) begin
            res.status = verdict;
            busy = 1'b0;
            outcomes.push_back(res);
            return;
         end
      end else if (pos >= mfhv_pkg::COMMON_LEN && 64'(pos) + 64'd1 >= hdr_len) begin
         // Last trailer byte of a header that passed every common header check.
         if (ver_acc[1:0] == mfhv_pkg::VER_SECTION) begin
            if (sect_acc > 64'(blob_len) - pend) begin
               res.status = mfhv_pkg::ST_TRUNC;
               busy = 1'b0;
               outcomes.push_back(res);
               return;
            end
            res.crc_word       = crc_acc;
            res.section_size   = sect_acc;
            res.section_offset = pend[47:0];
         end else begin
            res.hash_high = hash_hi_acc;
            res.hash_low  = hash_lo_acc;
            if (ver_acc[1:0] != mfhv_pkg::VER_PLAIN) begin
               res.crc_word       = crc_acc;
               res.section_size   = (64'(blob_len) > pend) ? 64'(blob_len) - pend : '0;
               res.section_offset = pend[47:0];
            end
         end
         res.status         = mfhv_pkg::ST_OK;
         res.version        = ver_acc[1:0];
         res.payload_size   = psize_acc;
         res.payload_offset = hdr_len[5:0];
         busy = 1'b0;
         outcomes.push_back(res);
         return;
      end
      offset = pos + 6'd1;
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         if (mismatches < 10)
            $display("%0t: %s differs: expected %0h, got %0h", $realtime, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      mfhv_pkg::rsp_type want;
      if (reset) begin
         cfg_magic   = '0;
         cfg_limit   = 32'hFFFF_FFFF;
         cfg_highest = 2'd3;
         busy        = 1'b0;
         offset      = '0;
         blob_len    = '0;
         outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mfhv_pkg::CSR_MAGIC:   cfg_magic   = csr_wdata;
               mfhv_pkg::CSR_LIMIT:   cfg_limit   = csr_wdata;
               mfhv_pkg::CSR_HIGHEST: cfg_highest = csr_wdata[1:0];
               default: ;
            endcase
         end
         if (req_push && !req_full)
            parse_byte(req_data);
         if (rsp_pop && !rsp_empty) begin
            if (outcomes.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result transfer with nothing awaited", $realtime);
               mismatches++;
            end else begin
               want = outcomes.pop_front();
               compare_field("status", 64'(want.status), 64'(rsp_data.status));
               compare_field("version", 64'(want.version), 64'(rsp_data.version));
               compare_field("payload_size", 64'(want.payload_size),
                             64'(rsp_data.payload_size));
               compare_field("payload_offset", 64'(want.payload_offset),
                             64'(rsp_data.payload_offset));
               compare_field("crc_word", 64'(want.crc_word), 64'(rsp_data.crc_word));
               compare_field("section_size", want.section_size, rsp_data.section_size);
               compare_field("section_offset", 64'(want.section_offset),
                             64'(rsp_data.section_offset));
               compare_field("hash_high", want.hash_high, rsp_data.hash_high);
               compare_field("hash_low", want.hash_low, rsp_data.hash_low);
            end
         end
      end
      mismatch_count <= mismatches;
      awaited_count  <= outcomes.size();
      parsed_count   <= live_items;
   end

endmodule

>>> tb/sv/model_file_header_validator_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// model_file_header_validator_tb: header validator testbench
// Streams blob headers into the validator under several register settings
// and flow-control patterns: a few hand-picked cases first, then random
// headers that are mostly well formed with random content, mixed with bad
// magic, bad versions, bad payload sizes, short and truncated blobs, cut headers
// and stray bytes. A separate scoreboard predicts and checks every result.
// ---------------------------------------------------------------------------
module model_file_header_validator_tb;

   localparam int ITEM_GOAL      = 1750;
   localparam int PHASES         = 8;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TRAILER_BYTES [4] = '{20, 16, 32, 40};

   logic              clock;
   logic              reset;
   logic              req_push;
   logic              req_full;
   mfhv_pkg::req_type req_data;
   logic              rsp_empty;
   logic              rsp_pop;
   mfhv_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic [31:0]       csr_wdata;

   int          mismatch_count;
   int          awaited_count;
   int          parsed_count;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   logic [31:0] cur_magic;
   logic [31:0] cur_limit;
   logic [1:0]  cur_highest;

   model_file_header_validator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   model_file_header_validator_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data       (req_data),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count),
      .parsed_count   (parsed_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Ends the run if the block stops moving.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic [47:0] size,
                            input logic start);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push           <= 1'b1;
      req_data.data_byte <= data;
      req_data.blob_size <= size;
      req_data.start_req <= start;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // Stops sending and waits until every awaited result has been popped,
   // then lets any bytes still in flight inside the block settle.
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic send_blob();
      logic [31:0] magic;
      logic [31:0] ver;
      logic [31:0] psize;
      logic [63:0] pend;
      logic [63:0] left;
      logic [63:0] sect;
      logic [47:0] blob;
      logic [7:0]  hdr_bytes [52];
      int          hdr;
      int          count;

      magic = cur_magic;
      if ($urandom_range(0, 9) == 0)
         magic = cur_magic ^ (32'd1 << $urandom_range(0, 31));

      case ($urandom_range(0, 19))
         0:       ver = 32'(cur_highest) + 32'd1;
         1:       ver = $urandom_range(4, 255);
         2:       ver = $urandom;
         default: ver = $urandom_range(0, cur_highest);
      endcase

      case ($urandom_range(0, 19))
         0:       psize = '0;
         1:       psize = cur_limit;
         2:       psize = cur_limit + 32'd1;
         3:       psize = $urandom;
         default: psize = $urandom_range(1, (cur_limit < 32'd4096) ? cur_limit : 32'd4096);
      endcase

      hdr  = 12 + TRAILER_BYTES[ver[1:0]];
      pend = 64'(hdr) + 64'(psize);
      case ($urandom_range(0, 19))
         0:       blob = 48'($urandom_range(0, 11));
         1:       blob = 48'(12 + $urandom_range(0, hdr - 13));
         2:       blob = pend[47:0] - 48'd1;
         3:       blob = 48'({$urandom, $urandom});
         4:       blob = pend[47:0];
         default: blob = pend[47:0] + 48'($urandom_range(0, 5000));
      endcase

      left = (64'(blob) > pend) ? 64'(blob) - pend : '0;
      case ($urandom_range(0, 9))
         0:       sect = left + 64'd1;
         1:       sect = {$urandom, $urandom};
         2:       sect = left;
         default: sect = {$urandom, $urandom} % (left + 64'd1);
      endcase

      for (int i = 0; i < 4; i++) begin
         hdr_bytes[i]     = magic[31 - 8*i -: 8];
         hdr_bytes[4 + i] = ver[31 - 8*i -: 8];
         hdr_bytes[8 + i] = psize[31 - 8*i -: 8];
      end
      for (int i = 12; i < 52; i++) hdr_bytes[i] = 8'($urandom);
      if (ver[1:0] == mfhv_pkg::VER_SECTION) begin
         for (int i = 0; i < 8; i++) hdr_bytes[16 + i] = sect[63 - 8*i -: 8];
      end

      // Now and then the header is cut short, so the next start drops it.
      count = hdr;
      if ($urandom_range(0, 11) == 0) count = $urandom_range(1, hdr - 1);

      for (int i = 0; i < count; i++)
         send_byte(hdr_bytes[i], (i == 0) ? blob : 48'({$urandom, $urandom}), i == 0);
      repeat ($urandom_range(0, 2))
         send_byte(8'($urandom), 48'({$urandom, $urandom}), 1'b0);
   endtask

   initial begin
      reset       = 1'b1;
      req_push    = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_index   = mfhv_pkg::CSR_MAGIC;
      csr_wdata   = '0;
      cur_magic   = '0;
      cur_limit   = 32'hFFFF_FFFF;
      cur_highest = 2'd3;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Hand-picked cases under the reset register values.
      send_byte(8'hFF, 48'd0, 1'b0);                 // stray byte while idle
      send_byte(8'h00, 48'd0, 1'b1);                 // empty blob
      send_byte(8'hFF, 48'd11, 1'b1);                // one byte short of the common header
      send_byte(8'hA5, 48'hFFFF_FFFF_FFFF, 1'b1);    // largest blob, dropped by a restart
      send_byte(8'hAB, 48'd0, 1'b0);
      send_byte(8'hCD, 48'hFFFF_FFFF_FFFF, 1'b0);
      // Common header fits but the version trailer does not.
      for (int i = 0; i < 12; i++)
         send_byte((i == 11) ? 8'h01 : 8'h00, 48'd12, i == 0);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0: begin cur_magic = '0;            cur_limit = 32'hFFFF_FFFF; cur_highest = 2'd3; end
            1: begin cur_magic = 32'hFFFF_FFFF; cur_limit = 32'hFFFF_FFFF; cur_highest = 2'd3; end
            2: begin cur_magic = $urandom;      cur_limit = '0;            cur_highest = 2'd3; end
            3: begin cur_magic = $urandom;      cur_limit = 32'd1;         cur_highest = 2'd0; end
            4: begin
               cur_magic   = $urandom;
               cur_limit   = $urandom_range(1, 65535);
               cur_highest = 2'd1;
            end
            5: begin cur_magic = $urandom;      cur_limit = 32'd4096;      cur_highest = 2'd2; end
            6: begin cur_magic = $urandom;      cur_limit = $urandom;      cur_highest = 2'd3; end
            default: begin
               cur_magic   = $urandom;
               cur_limit   = 32'hFFFF_FFFF;
               cur_highest = 2'd3;
            end
         endcase
         write_csr(mfhv_pkg::CSR_MAGIC, cur_magic);
         write_csr(mfhv_pkg::CSR_LIMIT, cur_limit);
         write_csr(mfhv_pkg::CSR_HIGHEST, {30'd0, cur_highest});
         csr_valid <= 1'b0;

         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase

         while (parsed_count < (p + 1) * ITEM_GOAL / PHASES) send_blob();
      end

      drain();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
src/mfhv_pkg.sv
src/mfhv_fifo.sv
src/mfhv_front.sv
src/mfhv_back.sv
src/model_file_header_validator.sv
tb/sv/model_file_header_validator_checker.sv
tb/sv/model_file_header_validator_tb.sv
